FILE: hw/rtl/dual_bank_image_slot_controller_unit_defines.svh
// Assertion macros for the image slot controller.
`ifndef DUAL_BANK_IMAGE_SLOT_CONTROLLER_UNIT_DEFINES_SVH
`define DUAL_BANK_IMAGE_SLOT_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DBISC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define DBISC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/dbisc_pkg.sv
// Types, codes and the CRC step shared by the image slot controller.
`timescale 1ns / 1ps
package dbisc_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

  localparam logic [31:0] MAGIC_RESET   = 32'd0;
  localparam logic [15:0] SIZE_RESET    = 16'd14224;
  localparam logic [31:0] TIMEOUT_RESET = 32'd30000;

  typedef enum logic [2:0] {
    MODE_HEADER   = 3'd0,
    MODE_IMAGE    = 3'd1,
    MODE_BEGIN    = 3'd2,
    MODE_ROLLBACK = 3'd3,
    MODE_TICK     = 3'd4,
    MODE_SELECT   = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BUSY     = 3'd1,
    ST_TOO_BIG  = 3'd2,
    ST_FAIL     = 3'd3,
    ST_NO_VALID = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CFG_MAGIC   = 2'd0,
    CFG_SIZE    = 2'd1,
    CFG_TIMEOUT = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic        slot;
    logic [31:0] header_magic;
    logic [15:0] image_size;
    logic [31:0] header_crc;
    logic [31:0] header_stamp;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic        active_slot_out;
    logic        slot_ok;
    logic        busy_flag;
    logic [31:0] crc_value;
    logic [31:0] success_count;
    logic [31:0] failure_count;
    logic [31:0] attempt_count;
    logic [31:0] last_success_tick;
  } out_item_t;

  typedef struct packed {
    logic     emit;
    out_item_t item;
  } result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/dbisc_if.sv
// Valid/ready channel interfaces for items and results.
`timescale 1ns / 1ps
interface dbisc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic        slot;
  logic [31:0] header_magic;
  logic [15:0] image_size;
  logic [31:0] header_crc;
  logic [31:0] header_stamp;
  logic [7:0]  data_byte;

  modport source(output valid, output mode, output slot, output header_magic,
                 output image_size, output header_crc, output header_stamp,
                 output data_byte, input ready);
  modport sink(input valid, input mode, input slot, input header_magic,
               input image_size, input header_crc, input header_stamp,
               input data_byte, output ready);
endinterface

interface dbisc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        active_slot_out;
  logic        slot_ok;
  logic        busy_flag;
  logic [31:0] crc_value;
  logic [31:0] success_count;
  logic [31:0] failure_count;
  logic [31:0] attempt_count;
  logic [31:0] last_success_tick;

  modport source(output valid, output status, output active_slot_out, output slot_ok,
                 output busy_flag, output crc_value, output success_count,
                 output failure_count, output attempt_count, output last_success_tick,
                 input ready);
  modport sink(input valid, input status, input active_slot_out, input slot_ok,
               input busy_flag, input crc_value, input success_count,
               input failure_count, input attempt_count, input last_success_tick,
               output ready);
endinterface

FILE: hw/rtl/dbisc_in_stage.sv
// Input register: holds one accepted item until the core takes it.
`timescale 1ns / 1ps
module dbisc_in_stage (
  input  logic              clk,
  input  logic              rst,
  dbisc_in_if.sink          in_ch,
  input  logic              slot_free,
  output logic              advance,
  output logic              stage_valid,
  output dbisc_pkg::in_item_t item
);

  logic in_xfer;

  assign advance     = stage_valid && slot_free;
  assign in_ch.ready = !stage_valid || advance;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_xfer) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item.mode         <= in_ch.mode;
      item.slot         <= in_ch.slot;
      item.header_magic <= in_ch.header_magic;
      item.image_size   <= in_ch.image_size;
      item.header_crc   <= in_ch.header_crc;
      item.header_stamp <= in_ch.header_stamp;
      item.data_byte    <= in_ch.data_byte;
    end
  end

endmodule

FILE: hw/rtl/dbisc_core.sv
// Slot state, counters, CRC and event handling for one item per cycle while the result register can take it.
`timescale 1ns / 1ps
module dbisc_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               advance,
  input  dbisc_pkg::in_item_t item,
  output dbisc_pkg::result_t  result
);

  logic [31:0] magic_value;
  logic [15:0] size_limit;
  logic [31:0] timeout_ticks;

  logic        active_bank, active_bank_next;
  logic [1:0]  bank_valid, bank_valid_next;
  logic [31:0] bank_stamp [2];
  logic [31:0] bank_stamp_next [2];
  logic        updating, updating_next;
  logic [31:0] update_start, update_start_next;
  logic [31:0] attempts, attempts_next;
  logic [31:0] successes, successes_next;
  logic [31:0] failures, failures_next;
  logic [31:0] last_success_time, last_success_time_next;
  logic [31:0] tick_count, tick_count_next;
  logic [31:0] crc_running, crc_running_next;
  logic [15:0] bytes_seen, bytes_seen_next;
  logic [15:0] bytes_expected, bytes_expected_next;
  logic [31:0] crc_expected, crc_expected_next;
  logic        stream_open, stream_open_next;
  logic        stream_bank, stream_bank_next;
  logic        stream_is_update, stream_is_update_next;

  logic        other;
  logic [31:0] crc_step;
  logic [15:0] seen_inc;
  logic [31:0] tick_inc;
  logic        close_req, close_bank, close_upd;
  logic [31:0] close_crc;
  logic        ok;
  dbisc_pkg::status_t st;

  assign other    = ~active_bank;
  assign crc_step = dbisc_pkg::crc_byte(crc_running, item.data_byte);
  assign seen_inc = bytes_seen + 16'd1;
  assign tick_inc = tick_count + 32'd1;

  always_comb begin
    active_bank_next       = active_bank;
    bank_valid_next        = bank_valid;
    bank_stamp_next        = bank_stamp;
    updating_next          = updating;
    update_start_next      = update_start;
    attempts_next          = attempts;
    successes_next         = successes;
    failures_next          = failures;
    last_success_time_next = last_success_time;
    tick_count_next        = tick_count;
    crc_running_next       = crc_running;
    bytes_seen_next        = bytes_seen;
    bytes_expected_next    = bytes_expected;
    crc_expected_next      = crc_expected;
    stream_open_next       = stream_open;
    stream_bank_next       = stream_bank;
    stream_is_update_next  = stream_is_update;
    close_req  = 1'b0;
    close_bank = 1'b0;
    close_upd  = 1'b0;
    close_crc  = dbisc_pkg::CRC_ONES;
    ok         = 1'b0;
    st         = dbisc_pkg::ST_OK;
    result.emit = 1'b0;

    case (item.mode)
      dbisc_pkg::MODE_HEADER: begin
        result.emit = 1'b1;
        if (stream_open) begin
          st = dbisc_pkg::ST_BUSY;
        end else if (item.header_magic != magic_value || item.image_size > size_limit) begin
          bank_valid_next[item.slot] = 1'b0;
          st = dbisc_pkg::ST_FAIL;
        end else begin
          bank_valid_next[item.slot] = 1'b0;
          bank_stamp_next[item.slot] = item.header_stamp;
          crc_expected_next     = item.header_crc;
          stream_open_next      = 1'b1;
          stream_bank_next      = item.slot;
          stream_is_update_next = 1'b0;
          bytes_expected_next   = item.image_size;
          bytes_seen_next       = 16'd0;
          crc_running_next      = dbisc_pkg::CRC_ONES;
          if (item.image_size == 16'd0) begin
            close_req  = 1'b1;
            close_bank = item.slot;
            close_upd  = 1'b0;
            close_crc  = dbisc_pkg::CRC_ONES;
          end
        end
      end
      dbisc_pkg::MODE_IMAGE: begin
        if (stream_open) begin
          crc_running_next = crc_step;
          bytes_seen_next  = seen_inc;
          if (seen_inc == bytes_expected) begin
            result.emit = 1'b1;
            close_req   = 1'b1;
            close_bank  = stream_bank;
            close_upd   = stream_is_update;
            close_crc   = crc_step;
          end
        end
      end
      dbisc_pkg::MODE_BEGIN: begin
        result.emit = 1'b1;
        if (stream_open || updating) begin
          st = dbisc_pkg::ST_BUSY;
        end else begin
          attempts_next     = attempts + 32'd1;
          update_start_next = tick_count;
          if (item.image_size > size_limit) begin
            failures_next = failures + 32'd1;
            st = dbisc_pkg::ST_TOO_BIG;
          end else begin
            updating_next          = 1'b1;
            bank_valid_next[other] = 1'b0;
            stream_open_next       = 1'b1;
            stream_bank_next       = other;
            stream_is_update_next  = 1'b1;
            bytes_expected_next    = item.image_size;
            bytes_seen_next        = 16'd0;
            crc_running_next       = dbisc_pkg::CRC_ONES;
            if (item.image_size == 16'd0) begin
              close_req  = 1'b1;
              close_bank = other;
              close_upd  = 1'b1;
              close_crc  = dbisc_pkg::CRC_ONES;
            end
          end
        end
      end
      dbisc_pkg::MODE_ROLLBACK: begin
        result.emit = 1'b1;
        if (bank_valid[other]) begin
          active_bank_next = other;
        end else begin
          st = dbisc_pkg::ST_FAIL;
        end
      end
      dbisc_pkg::MODE_TICK: begin
        result.emit     = 1'b1;
        tick_count_next = tick_inc;
        if (updating) begin
          if ((tick_inc - update_start) > timeout_ticks) begin
            if (bank_valid[other]) begin
              active_bank_next = other;
            end
            if (stream_is_update) begin
              stream_open_next = 1'b0;
            end
            updating_next = 1'b0;
            failures_next = failures + 32'd1;
            st = dbisc_pkg::ST_FAIL;
          end else begin
            st = dbisc_pkg::ST_BUSY;
          end
        end
      end
      dbisc_pkg::MODE_SELECT: begin
        result.emit = 1'b1;
        if (updating) begin
          st = dbisc_pkg::ST_BUSY;
        end else if (bank_valid[0] && bank_valid[1]) begin
          active_bank_next = (bank_stamp[0] > bank_stamp[1]) ? 1'b0 : 1'b1;
        end else if (bank_valid[0]) begin
          active_bank_next = 1'b0;
        end else if (bank_valid[1]) begin
          active_bank_next = 1'b1;
        end else begin
          st = dbisc_pkg::ST_NO_VALID;
        end
      end
      default: begin
        result.emit = 1'b0;
      end
    endcase

    if (close_req) begin
      stream_open_next = 1'b0;
      if (close_upd) begin
        bank_valid_next[close_bank] = 1'b1;
        bank_stamp_next[close_bank] = tick_count_next;
        active_bank_next       = close_bank;
        updating_next          = 1'b0;
        successes_next         = successes + 32'd1;
        last_success_time_next = tick_count_next;
        ok = 1'b1;
      end else begin
        ok = ((close_crc ^ dbisc_pkg::CRC_ONES) == crc_expected_next);
        bank_valid_next[close_bank] = ok;
      end
      if (ok) begin
        st = dbisc_pkg::ST_OK;
      end else begin
        st = dbisc_pkg::ST_FAIL;
      end
    end

    result.item.status            = st;
    result.item.active_slot_out   = active_bank_next;
    result.item.slot_ok           = ok;
    result.item.busy_flag         = updating_next;
    result.item.crc_value         = crc_running_next ^ dbisc_pkg::CRC_ONES;
    result.item.success_count     = successes_next;
    result.item.failure_count     = failures_next;
    result.item.attempt_count     = attempts_next;
    result.item.last_success_tick = last_success_time_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_value   <= dbisc_pkg::MAGIC_RESET;
      size_limit    <= dbisc_pkg::SIZE_RESET;
      timeout_ticks <= dbisc_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dbisc_pkg::CFG_MAGIC:   magic_value   <= cfg_data;
        dbisc_pkg::CFG_SIZE:    size_limit    <= cfg_data[15:0];
        dbisc_pkg::CFG_TIMEOUT: timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_bank       <= 1'b0;
      bank_valid        <= 2'b00;
      bank_stamp[0]     <= 32'd0;
      bank_stamp[1]     <= 32'd0;
      updating          <= 1'b0;
      update_start      <= 32'd0;
      attempts          <= 32'd0;
      successes         <= 32'd0;
      failures          <= 32'd0;
      last_success_time <= 32'd0;
      tick_count        <= 32'd0;
      crc_running       <= dbisc_pkg::CRC_ONES;
      bytes_seen        <= 16'd0;
      bytes_expected    <= 16'd0;
      crc_expected      <= 32'd0;
      stream_open       <= 1'b0;
      stream_bank       <= 1'b0;
      stream_is_update  <= 1'b0;
    end else if (advance) begin
      active_bank       <= active_bank_next;
      bank_valid        <= bank_valid_next;
      bank_stamp[0]     <= bank_stamp_next[0];
      bank_stamp[1]     <= bank_stamp_next[1];
      updating          <= updating_next;
      update_start      <= update_start_next;
      attempts          <= attempts_next;
      successes         <= successes_next;
      failures          <= failures_next;
      last_success_time <= last_success_time_next;
      tick_count        <= tick_count_next;
      crc_running       <= crc_running_next;
      bytes_seen        <= bytes_seen_next;
      bytes_expected    <= bytes_expected_next;
      crc_expected      <= crc_expected_next;
      stream_open       <= stream_open_next;
      stream_bank       <= stream_bank_next;
      stream_is_update  <= stream_is_update_next;
    end
  end

endmodule

FILE: hw/rtl/dbisc_out_stage.sv
// Result register driving the output channel.
`timescale 1ns / 1ps
module dbisc_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  dbisc_pkg::result_t result,
  output logic              slot_free,
  dbisc_out_if.source       out_ch
);

  logic            out_valid;
  logic            load;
  dbisc_pkg::out_item_t held;

  assign slot_free = !out_valid || out_ch.ready;
  assign load      = advance && result.emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result.item;
    end
  end

  assign out_ch.valid             = out_valid;
  assign out_ch.status            = held.status;
  assign out_ch.active_slot_out   = held.active_slot_out;
  assign out_ch.slot_ok           = held.slot_ok;
  assign out_ch.busy_flag         = held.busy_flag;
  assign out_ch.crc_value         = held.crc_value;
  assign out_ch.success_count     = held.success_count;
  assign out_ch.failure_count     = held.failure_count;
  assign out_ch.attempt_count     = held.attempt_count;
  assign out_ch.last_success_tick = held.last_success_tick;

endmodule

FILE: hw/rtl/dual_bank_image_slot_controller_unit.sv
// Path from an item transfer to its result transfer: input register, then result register.
// Throughput: one item per cycle while the output channel does not stall; the byte-wide CRC step is combinational.
// Items with no result (middle image bytes, unused modes) still pass through the input register and the core.
// Reset (rst, synchronous): both slots invalid, slot A active, counters zero,
// CRC preset to all ones, registers at their defaults; no clearing pass.
`timescale 1ns / 1ps
`include "dual_bank_image_slot_controller_unit_defines.svh"
module dual_bank_image_slot_controller_unit (
  input  logic        clk,
  input  logic        rst,
  dbisc_in_if.sink    in_ch,
  dbisc_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic                advance;
  logic                stage_valid;
  logic                slot_free;
  dbisc_pkg::in_item_t item;
  dbisc_pkg::result_t  result;

  dbisc_in_stage u_in (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .slot_free   (slot_free),
    .advance     (advance),
    .stage_valid (stage_valid),
    .item        (item)
  );

  dbisc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (advance),
    .item      (item),
    .result    (result)
  );

  dbisc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .result    (result),
    .slot_free (slot_free),
    .out_ch    (out_ch)
  );

  `DBISC_ASSERT_IMPL(a_ok_status, clk, rst, out_ch.valid && out_ch.slot_ok,
                     out_ch.status == dbisc_pkg::ST_OK, "slot_ok without ok status")
  `DBISC_ASSERT_IMPL(a_busy_not_ok, clk, rst, out_ch.valid && out_ch.busy_flag,
                     !out_ch.slot_ok, "slot_ok while update still busy")
  `DBISC_ASSERT_IMPL(a_stall_held, clk, rst, !in_ch.ready,
                     stage_valid && !slot_free, "input stalled with free stage")
  `DBISC_ASSERT_NEXT(a_emit_shows, clk, rst, advance && result.emit,
                     out_ch.valid, "result lost after load")

endmodule
